/* sv/sipq_pkg.sv */
// Shared types and constants for the sorted-insert priority queue.
// No dependencies; used by the cell, the top level and the checker.
`timescale 1ns / 1ps

package sipq_pkg;

   localparam int CODE_W  = 16;
   localparam int PRICE_W = 24;
   localparam int COUNT_W = 5;

   typedef enum logic [1:0] {
      OP_PUSH  = 2'd0,
      OP_POP   = 2'd1,
      OP_CLEAR = 2'd2
   } op_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_POP_EMPTY = 2'd1,
      ST_PUSH_FULL = 2'd2
   } status_type;

   typedef struct packed {
      logic [CODE_W-1:0]  code;
      logic [PRICE_W-1:0] price;
   } entry_type;

   // Broadcast to every cell in the row.
   typedef struct packed {
      logic      push;
      logic      pop;
      logic      clear;
      entry_type fresh;
   } cell_ctrl_type;

   // What a cell shows its neighbors.
   typedef struct packed {
      logic      valid;
      logic      greater;
      entry_type entry;
   } cell_link_type;

endpackage

/* sv/sipq_cell.sv */
// One slot of the sorted row: holds an entry, compares it with the pushed
// word and shifts toward its neighbors. Depends on sipq_pkg.
`timescale 1ns / 1ps

module sipq_cell (
   input  logic                   clock,
   input  logic                   reset,
   input  sipq_pkg::cell_ctrl_type ctrl,
   input  sipq_pkg::cell_link_type left,
   input  sipq_pkg::cell_link_type right,
   output sipq_pkg::cell_link_type link
);

   logic                valid_ff;
   logic                valid_in;
   sipq_pkg::entry_type entry_ff;
   sipq_pkg::entry_type entry_in;
   logic                greater;

   assign greater = valid_ff && (entry_ff.code > ctrl.fresh.code);

   always_comb begin
      valid_in = valid_ff;
      entry_in = entry_ff;
      priority if (ctrl.clear) begin
         valid_in = 1'b0;
      end else if (ctrl.pop) begin
         valid_in = right.valid;
         entry_in = right.entry;
      end else if (ctrl.push) begin
         if (left.greater) begin
            // make room: take the left neighbor's entry
            valid_in = left.valid;
            entry_in = left.entry;
         end else if (left.valid && (greater || !valid_ff)) begin
            // insertion point: after all equal or smaller codes
            valid_in = 1'b1;
            entry_in = ctrl.fresh;
         end
      end else begin
         // idle: hold the slot
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign link.valid   = valid_ff;
   assign link.greater = greater;
   assign link.entry   = entry_ff;

endmodule

/* sv/sorted_insert_priority_queue.sv */
// Top level of the sorted-insert priority queue: a row of sipq_cell slots,
// the entry count and the result register. Depends on sipq_pkg, sipq_cell.
//
//   channel | direction | handshake          | words
//   req_    | in        | req_valid/req_stall | operation, code, price_cents
//   rsp_    | out       | rsp_valid/rsp_stall | status, head, count, empty flag
//
// One word per cycle: every slot compares its code against the pushed code
// and shifts in the same cycle; the result follows in the next cycle.
// Reset is synchronous and empties the queue.
// While a result is stalled, req_stall is high and no new word is taken.
`timescale 1ns / 1ps

module sorted_insert_priority_queue #(
   parameter int DEPTH = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_operation,
   input  logic [15:0] req_code,
   input  logic [23:0] req_price_cents,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_status,
   output logic [15:0] rsp_head_code,
   output logic [23:0] rsp_head_price_cents,
   output logic [4:0]  rsp_entry_count,
   output logic        rsp_queue_empty
);

   localparam int CNT_W = $clog2(DEPTH + 1);

   sipq_pkg::cell_ctrl_type ctrl;
   sipq_pkg::cell_link_type links [DEPTH];
   sipq_pkg::status_type    status;
   sipq_pkg::op_type        op;

   logic             accept;
   logic             full;
   logic             empty;
   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;

   logic                         rsp_valid_ff;
   logic [1:0]                   status_ff;
   logic [sipq_pkg::CODE_W-1:0]  head_code_ff;
   logic [sipq_pkg::PRICE_W-1:0] head_price_ff;
   logic [sipq_pkg::COUNT_W-1:0] count_out_ff;
   logic                         empty_ff;

   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;
   assign op        = sipq_pkg::op_type'(req_operation);
   assign empty     = !links[0].valid;
   assign full      = links[DEPTH-1].valid;

   always_comb begin
      ctrl.push        = 1'b0;
      ctrl.pop         = 1'b0;
      ctrl.clear       = 1'b0;
      ctrl.fresh.code  = req_code;
      ctrl.fresh.price = req_price_cents;
      status           = sipq_pkg::ST_OK;
      count_in         = count_ff;
      if (accept) begin
         unique case (op)
            sipq_pkg::OP_PUSH: begin
               if (full) begin
                  status = sipq_pkg::ST_PUSH_FULL;
               end else begin
                  ctrl.push = 1'b1;
                  count_in  = count_ff + CNT_W'(1);
               end
            end
            sipq_pkg::OP_POP: begin
               if (empty) begin
                  status = sipq_pkg::ST_POP_EMPTY;
               end else begin
                  ctrl.pop = 1'b1;
                  count_in = count_ff - CNT_W'(1);
               end
            end
            sipq_pkg::OP_CLEAR: begin
               ctrl.clear = 1'b1;
               count_in   = '0;
            end
            default: begin
               // unused code: leave the queue alone
            end
         endcase
      end
   end

   genvar g;
   generate
      for (g = 0; g < DEPTH; g++) begin : g_cell
         sipq_pkg::cell_link_type left_link;
         sipq_pkg::cell_link_type right_link;
         if (g == 0) begin : g_first
            assign left_link.valid   = 1'b1;
            assign left_link.greater = 1'b0;
            assign left_link.entry   = '0;
         end else begin : g_mid
            assign left_link = links[g-1];
         end
         if (g == DEPTH - 1) begin : g_last
            assign right_link.valid   = 1'b0;
            assign right_link.greater = 1'b0;
            assign right_link.entry   = '0;
         end else begin : g_next
            assign right_link = links[g+1];
         end
         sipq_cell u_cell (
            .clock (clock),
            .reset (reset),
            .ctrl  (ctrl),
            .left  (left_link),
            .right (right_link),
            .link  (links[g])
         );
      end
   endgenerate

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         if (accept) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // hold the result word while stalled; load on accept
   always_ff @(posedge clock) begin
      if (accept) begin
         status_ff     <= status;
         head_code_ff  <= ctrl.pop ? links[0].entry.code  : '0;
         head_price_ff <= ctrl.pop ? links[0].entry.price : '0;
         count_out_ff  <= sipq_pkg::COUNT_W'(count_in);
         empty_ff      <= (count_in == '0);
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_status           = status_ff;
   assign rsp_head_code        = head_code_ff;
   assign rsp_head_price_cents = head_price_ff;
   assign rsp_entry_count      = count_out_ff;
   assign rsp_queue_empty      = empty_ff;

endmodule

/* sv/sipq_check.sv */
// Port-level checks for the sorted-insert priority queue, bound to the top.
// Depends on sipq_pkg and sorted_insert_priority_queue.
`timescale 1ns / 1ps

module sipq_check (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [1:0]  rsp_status,
   input logic [15:0] rsp_head_code,
   input logic [23:0] rsp_head_price_cents,
   input logic [4:0]  rsp_entry_count,
   input logic        rsp_queue_empty
);

   // every accepted word yields a result in the next cycle
   a_accept_result: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> rsp_valid)
      else $error("accepted word produced no result");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_status)
         && $stable(rsp_head_code) && $stable(rsp_head_price_cents)
         && $stable(rsp_entry_count) && $stable(rsp_queue_empty))
      else $error("stalled result changed");

   a_fail_no_head: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != sipq_pkg::ST_OK
         |-> rsp_head_code == '0 && rsp_head_price_cents == '0)
      else $error("failed operation returned a head entry");

   a_pop_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == sipq_pkg::ST_POP_EMPTY
         |-> rsp_queue_empty && rsp_entry_count == '0)
      else $error("pop on empty left entries behind");

   a_push_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == sipq_pkg::ST_PUSH_FULL |-> !rsp_queue_empty)
      else $error("full queue reported empty");

endmodule

bind sorted_insert_priority_queue sipq_check u_sipq_check (
   .clock                (clock),
   .reset                (reset),
   .req_valid            (req_valid),
   .req_stall            (req_stall),
   .rsp_valid            (rsp_valid),
   .rsp_stall            (rsp_stall),
   .rsp_status           (rsp_status),
   .rsp_head_code        (rsp_head_code),
   .rsp_head_price_cents (rsp_head_price_cents),
   .rsp_entry_count      (rsp_entry_count),
   .rsp_queue_empty      (rsp_queue_empty)
);
